/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CKHR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CKHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CKHR_ASSERT_NOW(label, clk, rst, ante, cons)
`define CKHR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/ckhr_pkg.sv */
// ----------------------------------------------------------------------------
// ckhr_pkg
// Types and constants for the chroma key hue replace core.
// ----------------------------------------------------------------------------
package ckhr_pkg;

   typedef logic [7:0] ckhr_chan_type;
   typedef logic [8:0] ckhr_hue_type;
   typedef logic [2:0] ckhr_reg_idx_type;

   localparam int unsigned CKHR_ADDR_WIDTH = 5;
   localparam int unsigned CKHR_DATA_WIDTH = 32;

   localparam ckhr_reg_idx_type CKHR_REG_HUE_LOW    = 3'd0;
   localparam ckhr_reg_idx_type CKHR_REG_HUE_HIGH   = 3'd1;
   localparam ckhr_reg_idx_type CKHR_REG_GREEN_FLR  = 3'd2;
   localparam ckhr_reg_idx_type CKHR_REG_KEY_RED    = 3'd3;
   localparam ckhr_reg_idx_type CKHR_REG_KEY_GREEN  = 3'd4;
   localparam ckhr_reg_idx_type CKHR_REG_KEY_BLUE   = 3'd5;

   localparam ckhr_hue_type  CKHR_RST_HUE_LOW   = 9'd80;
   localparam ckhr_hue_type  CKHR_RST_HUE_HIGH  = 9'd195;
   localparam ckhr_chan_type CKHR_RST_GREEN_FLR = 8'd70;
   localparam ckhr_chan_type CKHR_RST_KEY_RED   = 8'd255;
   localparam ckhr_chan_type CKHR_RST_KEY_GREEN = 8'd0;
   localparam ckhr_chan_type CKHR_RST_KEY_BLUE  = 8'd255;

   // hue sector offsets, degrees
   localparam ckhr_hue_type CKHR_SECTOR_GREEN = 9'd120;
   localparam ckhr_hue_type CKHR_SECTOR_BLUE  = 9'd240;
   localparam ckhr_hue_type CKHR_SECTOR_WRAP  = 9'd360;
   localparam logic signed [18:0] CKHR_DEG_PER_STEP = 19'sd60;

endpackage

/* design/ckhr_req_if.sv */
// ----------------------------------------------------------------------------
// ckhr_req_if
// Pixel request channel: valid/ready with one RGB pixel.
// ----------------------------------------------------------------------------
interface ckhr_req_if;
   import ckhr_pkg::*;

   logic          valid;
   logic          ready;
   ckhr_chan_type in_red;
   ckhr_chan_type in_green;
   ckhr_chan_type in_blue;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   output ready);
endinterface

/* design/ckhr_rsp_if.sv */
// ----------------------------------------------------------------------------
// ckhr_rsp_if
// Result channel: valid/ready with the result pixel and key flag.
// ----------------------------------------------------------------------------
interface ckhr_rsp_if;
   import ckhr_pkg::*;

   logic          valid;
   logic          ready;
   ckhr_chan_type out_red;
   ckhr_chan_type out_green;
   ckhr_chan_type out_blue;
   logic          keyed;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output keyed, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input keyed, output ready);
endinterface

/* design/chroma_key_hue_replace_core.sv */
// ----------------------------------------------------------------------------
// chroma_key_hue_replace_core
// Computes the HSV hue of each pixel by exact cross-multiplication, keys it
// against a hue window and green floor, and substitutes the key color.
// ----------------------------------------------------------------------------
//   channel   direction  handshake        payload
//   req_pix   in         valid/ready      in_red, in_green, in_blue
//   rsp_pix   out        valid/ready      out_red, out_green, out_blue, keyed
//   csr_*     in         APB, pready=1    six registers at 4*index
//
// One request per cycle sustained while results are taken; pixels pass the
// input register, then the result register. The hue test between them is
// one pass of small 9x8 multiplies and compares. A stalled result holds the
// result register and the input register fills behind it. Reset
// (synchronous) empties both stages and restores the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chroma_key_hue_replace_core (
   input  logic                               clock,
   input  logic                               reset,
   ckhr_req_if.sink                           req_pix,
   ckhr_rsp_if.source                         rsp_pix,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ckhr_pkg::CKHR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [ckhr_pkg::CKHR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [ckhr_pkg::CKHR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import ckhr_pkg::*;

   // configuration
   ckhr_hue_type     hue_low_ff, hue_high_ff;
   ckhr_chan_type    green_floor_ff, key_red_ff, key_green_ff, key_blue_ff;
   ckhr_reg_idx_type csr_idx;
   logic             csr_wr;

   // pipeline
   logic          s1_valid_ff, s1_valid_in;
   ckhr_chan_type s1_red_ff, s1_green_ff, s1_blue_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   ckhr_chan_type rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   ckhr_chan_type rsp_red_in, rsp_green_in, rsp_blue_in;
   logic          rsp_keyed_ff, rsp_keyed_in;
   logic          s1_advance, req_take;

   // hue datapath
   ckhr_chan_type     mx, mn, dlt, dx, dy;
   logic              red_max, green_max;
   ckhr_hue_type      base;
   logic [16:0]       base_d, lo_prod, hi_prod, n_val;
   logic signed [8:0] diff;
   logic signed [18:0] diff_w, diff_x60, n_sgn;
   logic              in_range, green_ok;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CKHR_ADDR_WIDTH-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff     <= CKHR_RST_HUE_LOW;
         hue_high_ff    <= CKHR_RST_HUE_HIGH;
         green_floor_ff <= CKHR_RST_GREEN_FLR;
         key_red_ff     <= CKHR_RST_KEY_RED;
         key_green_ff   <= CKHR_RST_KEY_GREEN;
         key_blue_ff    <= CKHR_RST_KEY_BLUE;
      end else if (csr_wr) begin
         case (csr_idx)
            CKHR_REG_HUE_LOW:   hue_low_ff     <= csr_pwdata[8:0];
            CKHR_REG_HUE_HIGH:  hue_high_ff    <= csr_pwdata[8:0];
            CKHR_REG_GREEN_FLR: green_floor_ff <= csr_pwdata[7:0];
            CKHR_REG_KEY_RED:   key_red_ff     <= csr_pwdata[7:0];
            CKHR_REG_KEY_GREEN: key_green_ff   <= csr_pwdata[7:0];
            CKHR_REG_KEY_BLUE:  key_blue_ff    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CKHR_REG_HUE_LOW:   csr_prdata = {23'd0, hue_low_ff};
         CKHR_REG_HUE_HIGH:  csr_prdata = {23'd0, hue_high_ff};
         CKHR_REG_GREEN_FLR: csr_prdata = {24'd0, green_floor_ff};
         CKHR_REG_KEY_RED:   csr_prdata = {24'd0, key_red_ff};
         CKHR_REG_KEY_GREEN: csr_prdata = {24'd0, key_green_ff};
         CKHR_REG_KEY_BLUE:  csr_prdata = {24'd0, key_blue_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // handshake
   assign s1_advance    = !rsp_valid_ff || rsp_pix.ready;
   assign req_pix.ready = !s1_valid_ff || s1_advance;
   assign req_take      = req_pix.valid && req_pix.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (req_pix.ready) begin
         s1_valid_in = req_pix.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_red_ff   <= req_pix.in_red;
         s1_green_ff <= req_pix.in_green;
         s1_blue_ff  <= req_pix.in_blue;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
         rsp_keyed_ff <= rsp_keyed_in;
      end
   end

   // hue = n / d, tested as lo*d <= n <= hi*d
   always_comb begin
      mx = (s1_red_ff > s1_green_ff) ? s1_red_ff : s1_green_ff;
      mx = (mx > s1_blue_ff) ? mx : s1_blue_ff;
      mn = (s1_red_ff < s1_green_ff) ? s1_red_ff : s1_green_ff;
      mn = (mn < s1_blue_ff) ? mn : s1_blue_ff;
      dlt = mx - mn;
      red_max   = (s1_red_ff == mx);
      green_max = (s1_green_ff == mx);

      if (red_max) begin
         dx   = s1_green_ff;
         dy   = s1_blue_ff;
         base = (s1_green_ff < s1_blue_ff) ? CKHR_SECTOR_WRAP : 9'd0;
      end else if (green_max) begin
         dx   = s1_blue_ff;
         dy   = s1_red_ff;
         base = CKHR_SECTOR_GREEN;
      end else begin
         dx   = s1_red_ff;
         dy   = s1_green_ff;
         base = CKHR_SECTOR_BLUE;
      end

      diff     = $signed({1'b0, dx}) - $signed({1'b0, dy});
      diff_w   = 19'(diff);
      diff_x60 = diff_w * CKHR_DEG_PER_STEP;
      base_d   = {8'd0, base} * {9'd0, dlt};
      n_sgn    = $signed({2'b00, base_d}) + diff_x60;
      n_val    = n_sgn[16:0];
      lo_prod  = {8'd0, hue_low_ff} * {9'd0, dlt};
      hi_prod  = {8'd0, hue_high_ff} * {9'd0, dlt};

      if (dlt == 8'd0) begin
         in_range = (hue_low_ff == 9'd0);   // grey pixel, hue 0
      end else begin
         in_range = (n_val >= lo_prod) && (n_val <= hi_prod);
      end
      green_ok     = (s1_green_ff > green_floor_ff);
      rsp_keyed_in = in_range && green_ok;

      if (rsp_keyed_in) begin
         rsp_red_in   = key_red_ff;
         rsp_green_in = key_green_ff;
         rsp_blue_in  = key_blue_ff;
      end else begin
         rsp_red_in   = s1_red_ff;
         rsp_green_in = s1_green_ff;
         rsp_blue_in  = s1_blue_ff;
      end
   end

   assign rsp_pix.valid     = rsp_valid_ff;
   assign rsp_pix.out_red   = rsp_red_ff;
   assign rsp_pix.out_green = rsp_green_ff;
   assign rsp_pix.out_blue  = rsp_blue_ff;
   assign rsp_pix.keyed     = rsp_keyed_ff;

   `CKHR_ASSERT_NOW(a_s1_full_blocks, clock, reset, s1_valid_ff && !s1_advance, !req_pix.ready)
   `CKHR_ASSERT_NEXT(a_s1_moves_out, clock, reset, s1_valid_ff && s1_advance, rsp_valid_ff)
   `CKHR_ASSERT_NEXT(a_s1_holds_on_stall, clock, reset,
                     s1_valid_ff && rsp_valid_ff && !rsp_pix.ready, s1_valid_ff)

endmodule
